@@ rtl/mam_pkg.sv @@
`timescale 1ns / 1ps
// mam_pkg: widths, reset values, sequencer states and control structs for
// the matrix add/multiply block. No dependencies.
package mam_pkg;

  localparam int unsigned MAX_N_DEF = 8;     // largest supported matrix size
  localparam int unsigned SIZE_W    = 4;     // matrix_size register width
  localparam int unsigned IDX_W     = 3;     // row/col index width
  localparam int unsigned ELEM_W    = 32;    // matrix element width
  localparam int unsigned SUM_W     = 33;    // exact element sum width
  localparam int unsigned PROD_W    = 64;    // dot product width

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  typedef enum logic [1:0] {
    ST_LOAD,   // taking elements of A then B
    ST_ISSUE,  // one MAC operand pair per cycle
    ST_DRAIN,  // wait for the MAC pipeline to finish
    ST_EMIT    // hand the result to the output register
  } seq_state_e;

  // sequencer -> MAC, aligned with the operand read request
  typedef struct packed {
    logic issue;  // operand pair requested this cycle
    logic first;  // k == 0, restart the accumulator
    logic last;   // k == n-1, result complete after this one
  } mac_ctl_t;

endpackage

@@ rtl/mam_in_if.sv @@
`timescale 1ns / 1ps
// mam_in_if: input word channel (one matrix element per word).
// Depends on mam_pkg.
interface mam_in_if import mam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

@@ rtl/mam_out_if.sv @@
`timescale 1ns / 1ps
// mam_out_if: result word channel (one result element per word).
// Depends on mam_pkg.
interface mam_out_if import mam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [IDX_W-1:0]  row_index;
  logic        [IDX_W-1:0]  col_index;
  logic signed [SUM_W-1:0]  sum_value;
  logic signed [PROD_W-1:0] product_value;
  logic                     last_result;

  modport source (output valid, output row_index, output col_index, output sum_value,
                  output product_value, output last_result, input ready);
  modport sink   (input valid, input row_index, input col_index, input sum_value,
                  input product_value, input last_result, output ready);
endinterface

@@ rtl/mam_mem.sv @@
`timescale 1ns / 1ps
// mam_mem: matrix store, one write port and two registered read ports.
// Depends on mam_pkg.
module mam_mem import mam_pkg::*; #(
  parameter int unsigned DEPTH = MAX_N_DEF * MAX_N_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [ELEM_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr0_i,
  input  logic [AW-1:0]     raddr1_i,
  output logic [ELEM_W-1:0] rdata0_o,
  output logic [ELEM_W-1:0] rdata1_o
);

  logic [ELEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_o <= mem[raddr0_i];
    rdata1_o <= mem[raddr1_i];
  end

endmodule

@@ rtl/mam_mac.sv @@
`timescale 1ns / 1ps
// mam_mac: shared multiply-accumulate unit. Operands arrive in the cycle after
// the request in ctl_i; product and sum are each registered. Depends on mam_pkg.
module mam_mac import mam_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mac_ctl_t                 ctl_i,
  input  logic signed [ELEM_W-1:0] a_i,
  input  logic signed [ELEM_W-1:0] b_i,
  output logic signed [PROD_W-1:0] acc_o,
  output logic                     done_o
);

  mac_ctl_t                 ctl1_q, ctl2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] acc_q;
  logic                     done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      done_q <= 1'b0;
    end else begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      done_q <= ctl2_q.issue && ctl2_q.last;
    end
  end

  // operands sign-extend to the 64-bit context
  always_ff @(posedge clk_i) begin
    if (ctl1_q.issue) begin
      prod_q <= a_i * b_i;
    end
    if (ctl2_q.issue) begin
      acc_q <= (ctl2_q.first ? '0 : acc_q) + prod_q;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

@@ rtl/mam_seq.sv @@
`timescale 1ns / 1ps
// mam_seq: size register, load counters and the compute sequencer that walks
// i, j, k and drives the stores and the MAC. Depends on mam_pkg.
module mam_seq import mam_pkg::*; #(
  parameter int unsigned MAX_N = MAX_N_DEF,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mac_done_i,
  input  logic              out_free_i,
  output mac_ctl_t          mac_ctl_o,
  output logic              emit_o,
  output logic              we_a_o,
  output logic              we_b_o,
  output logic [AW-1:0]     waddr_o,
  output logic [AW-1:0]     raddr_a_o,
  output logic [AW-1:0]     raddr_b_o,
  output logic [AW-1:0]     raddr_c_o,
  output logic [IDX_W-1:0]  row_o,
  output logic [IDX_W-1:0]  col_o,
  output logic              last_o
);

  localparam logic [AW-1:0]     ROW_STRIDE = AW'(MAX_N);
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_N);

  seq_state_e        state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] n_eff;
  logic [IDX_W-1:0]  nm1;
  logic              phase_q, phase_d;          // 0: loading A, 1: loading B
  logic [IDX_W-1:0]  lr_q, lr_d, lc_q, lc_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic              accept;
  logic              load_done;
  logic              k_last, j_last, i_last;

  always_comb begin
    n_eff = size_q;
    if (size_q == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_q > SIZE_MAX) begin
      n_eff = SIZE_MAX;
    end
  end
  assign nm1 = IDX_W'(n_eff - SIZE_W'(1));

  assign accept    = in_valid_i && in_ready_o;
  assign load_done = accept && phase_q && (lr_q == nm1) && (lc_q == nm1);
  assign k_last    = (k_q == nm1);
  assign j_last    = (j_q == nm1);
  assign i_last    = (i_q == nm1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:  if (load_done)  state_d = ST_ISSUE;
      ST_ISSUE: if (k_last)     state_d = ST_DRAIN;
      ST_DRAIN: if (mac_done_i) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = (i_last && j_last) ? ST_LOAD : ST_ISSUE;
        end
      end
      default:                  state_d = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    emit_o          = 1'b0;
    mac_ctl_o       = '0;
    unique case (state_q)
      ST_LOAD:  in_ready_o = 1'b1;
      ST_ISSUE: begin
        mac_ctl_o.issue = 1'b1;
        mac_ctl_o.first = (k_q == '0);
        mac_ctl_o.last  = k_last;
      end
      ST_DRAIN: ;
      ST_EMIT:  emit_o = out_free_i;
      default:  ;
    endcase
  end

  // counters
  always_comb begin
    phase_d = phase_q;
    lr_d    = lr_q;
    lc_d    = lc_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    if (cfg_we_i) begin
      phase_d = 1'b0;
      lr_d    = '0;
      lc_d    = '0;
    end else if (accept) begin
      if (lc_q == nm1) begin
        lc_d = '0;
        if (lr_q == nm1) begin
          lr_d    = '0;
          phase_d = !phase_q;
        end else begin
          lr_d = lr_q + IDX_W'(1);
        end
      end else begin
        lc_d = lc_q + IDX_W'(1);
      end
    end
    if (state_q == ST_ISSUE) begin
      k_d = k_last ? '0 : k_q + IDX_W'(1);
    end
    if (emit_o) begin
      if (j_last) begin
        j_d = '0;
        i_d = i_last ? '0 : i_q + IDX_W'(1);
      end else begin
        j_d = j_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      size_q  <= SIZE_RESET;
      phase_q <= 1'b0;
      lr_q    <= '0;
      lc_q    <= '0;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      lr_q    <= lr_d;
      lc_q    <= lc_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign we_a_o    = accept && !phase_q;
  assign we_b_o    = accept && phase_q;
  assign waddr_o   = AW'(lr_q) * ROW_STRIDE + AW'(lc_q);
  assign raddr_a_o = AW'(i_q) * ROW_STRIDE + AW'(k_q);
  assign raddr_b_o = AW'(k_q) * ROW_STRIDE + AW'(j_q);
  assign raddr_c_o = AW'(i_q) * ROW_STRIDE + AW'(j_q);
  assign row_o     = i_q;
  assign col_o     = j_q;
  assign last_o    = i_last && j_last;

endmodule

@@ rtl/matrix_add_multiply.sv @@
`timescale 1ns / 1ps
// matrix_add_multiply: top level. Loads A and B, then streams A+B and A*B.
// Depends on mam_pkg, mam_in_if, mam_out_if, mam_seq, mam_mem, mam_mac.
//
//   channel   | dir | word                                   | handshake
//   ----------+-----+----------------------------------------+-------------
//   cfg       | in  | matrix_size (4b)                       | cfg_we_i only
//   elem_in   | in  | element_value (s32)                    | valid/ready
//   res_out   | out | row, col, sum (s33), product (s64), last | valid/ready
//
// Load: one element per cycle, 2*n*n words (A then B, row-major).
// Compute: one shared 32x32 MAC fed from the two stores, one operand pair per
//   cycle while issuing; each result is issued (n reads), drained from the MAC
//   pipeline and emitted before the next begins, waiting while output is full.
// elem_in.ready is low from the last B word until the last result is in the
//   output register; the output register lets a new load start while the
//   final word waits.
// Reset clears control state and sets matrix_size to 8; stores are not cleared.
// A matrix_size of 0 acts as 1, values above MAX_N act as MAX_N; a write
//   restarts the load at A[0][0].
module matrix_add_multiply import mam_pkg::*; #(
  parameter int unsigned MAX_N = MAX_N_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_data_i,
  mam_in_if.sink            elem_in,
  mam_out_if.source         res_out
);

  localparam int unsigned DEPTH = MAX_N * MAX_N;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mac_ctl_t                 mac_ctl;
  logic                     mac_done;
  logic signed [PROD_W-1:0] acc;
  logic                     emit;
  logic                     out_free;
  logic                     we_a, we_b;
  logic [AW-1:0]            waddr, raddr_a, raddr_b, raddr_c;
  logic [IDX_W-1:0]         row, col;
  logic                     last;
  logic [ELEM_W-1:0]        a_k, b_k, a_ij, b_ij;

  // output register
  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [SUM_W-1:0]  out_sum_q;
  logic signed [PROD_W-1:0] out_prod_q;
  logic                     out_last_q;

  assign out_free = !out_valid_q || res_out.ready;

  mam_seq #(
    .MAX_N (MAX_N),
    .AW    (AW)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (elem_in.valid),
    .in_ready_o (elem_in.ready),
    .mac_done_i (mac_done),
    .out_free_i (out_free),
    .mac_ctl_o  (mac_ctl),
    .emit_o     (emit),
    .we_a_o     (we_a),
    .we_b_o     (we_b),
    .waddr_o    (waddr),
    .raddr_a_o  (raddr_a),
    .raddr_b_o  (raddr_b),
    .raddr_c_o  (raddr_c),
    .row_o      (row),
    .col_o      (col),
    .last_o     (last)
  );

  // store A: port 0 walks row i, port 1 holds (i, j) for the sum
  mam_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (waddr),
    .wdata_i  (elem_in.element_value),
    .raddr0_i (raddr_a),
    .raddr1_i (raddr_c),
    .rdata0_o (a_k),
    .rdata1_o (a_ij)
  );

  // store B: port 0 walks column j
  mam_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (waddr),
    .wdata_i  (elem_in.element_value),
    .raddr0_i (raddr_b),
    .raddr1_i (raddr_c),
    .rdata0_o (b_k),
    .rdata1_o (b_ij)
  );

  mam_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (a_k),
    .b_i    (b_k),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (res_out.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_row_q  <= row;
      out_col_q  <= col;
      out_sum_q  <= SUM_W'($signed(a_ij)) + SUM_W'($signed(b_ij));
      out_prod_q <= acc;
      out_last_q <= last;
    end
  end

  assign res_out.valid         = out_valid_q;
  assign res_out.row_index     = out_row_q;
  assign res_out.col_index     = out_col_q;
  assign res_out.sum_value     = out_sum_q;
  assign res_out.product_value = out_prod_q;
  assign res_out.last_result   = out_last_q;

endmodule

@@ rtl/mam_chk.sv @@
`timescale 1ns / 1ps
// mam_chk: port-level checks for matrix_add_multiply, bound to the top level.
// Depends on mam_pkg.
module mam_chk import mam_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_i,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [IDX_W-1:0]         row_i,
  input logic [IDX_W-1:0]         col_i,
  input logic signed [SUM_W-1:0]  sum_i,
  input logic signed [PROD_W-1:0] prod_i,
  input logic                     last_i
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(row_i) && $stable(col_i)
      && $stable(sum_i) && $stable(prod_i) && $stable(last_i))
    else $error("result word changed while stalled");

  // the block stops taking input only on the word that completes a load
  a_ready_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_ready_i))
    else $error("input ready dropped without an accepted word");

  // results are produced only while input is held off
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared during a load");

  // the final result sits on the diagonal
  a_last_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> row_i == col_i)
    else $error("last result off the diagonal");

endmodule

bind matrix_add_multiply mam_chk u_mam_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (elem_in.valid),
  .in_ready_i  (elem_in.ready),
  .out_valid_i (res_out.valid),
  .out_ready_i (res_out.ready),
  .row_i       (res_out.row_index),
  .col_i       (res_out.col_index),
  .sum_i       (res_out.sum_value),
  .prod_i      (res_out.product_value),
  .last_i      (res_out.last_result)
);
